FILE: src/trit_pkg.sv
// ----------------------------------------------------------------------------
// trit_pkg: shared types and constants of the track range index table
// item and result formats, the queued operation format, table geometry
// ----------------------------------------------------------------------------
package trit_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int ADDR_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int USED_W     = $clog2(MAX_BLOCKS + 1);
	localparam int OFFSET_W   = 31;
	localparam int LEN_W      = 16;
	localparam int TRACK_W    = 16;
	localparam int TCOUNT_W   = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [OFFSET_W-1:0] stream_offset;
		logic [LEN_W-1:0]    block_bytes;
		logic [TCOUNT_W-1:0] tracks_in_block;
		logic [TRACK_W-1:0]  track_number;
	} item_t;

	typedef struct packed {
		logic                ok;
		logic [OFFSET_W-1:0] found_offset;
		logic [LEN_W-1:0]    found_length;
		logic [TRACK_W-1:0]  found_first_track;
		logic [TRACK_W-1:0]  total_tracks;
	} result_t;

	// one table entry as stored in the back end memory
	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [LEN_W-1:0]    length;
		logic [TRACK_W-1:0]  first_track;
		logic [TCOUNT_W-1:0] track_count;
	} entry_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic                cmd;
		logic                ok;           // append accepted, or lookup below total
		logic [ADDR_W-1:0]   wr_index;
		entry_t              entry;
		logic [TRACK_W-1:0]  track_number;
		logic [TRACK_W-1:0]  total_tracks;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

endpackage

FILE: src/track_range_index_table_top.sv
// ----------------------------------------------------------------------------
// track_range_index_table_top: append-only table of track range index blocks
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: present an item and raise push; it is taken at a
//   clock edge where push is high and full is low. cmd selects append or
//   lookup. output side is a queue: while empty is low the oldest result is
//   on result, and raising pop takes it.
// operation flow
//   items are classified on entry and queued (four deep) for the back end,
//   which handles one item at a time. an append or a lookup miss goes from
//   queue head through the idle and emit states to the result and holds the
//   back end until the result is loaded. a lookup hit walks the entry memory
//   one entry per cycle through its single registered read port, from the
//   first entry up to the covering block, then emits its result.
// reset
//   arst_n clears the entry count, track total, queue and result slot; the
//   entry memory is not cleared, only written entries are ever scanned.
// stalls
//   with pop held low the held result stays put, the back end finishes its
//   next item and waits, and the front keeps taking items until the queue
//   fills, then raises full.
// ----------------------------------------------------------------------------
module track_range_index_table_top import trit_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	// front to queue
	logic op_push;
	logic op_full;
	op_t  op_wr;

	// queue to back
	logic op_empty;
	logic op_pop;
	op_t  op_rd;

	// classify items and keep the running counts
	trit_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_full (op_full),
		.op_push (op_push),
		.op      (op_wr)
	);

	// decouples item intake from the memory walk
	trit_op_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_push),
		.wr_data (op_wr),
		.full    (op_full),
		.rd_en   (op_pop),
		.rd_data (op_rd),
		.empty   (op_empty)
	);

	// entry memory, lookup scan and result slot
	trit_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op_in    (op_rd),
		.op_pop   (op_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

FILE: src/trit_front.sv
// ----------------------------------------------------------------------------
// trit_front: accepts items and classifies them
// keeps the entry count and track total, decides appends, screens lookups
// ----------------------------------------------------------------------------
module trit_front import trit_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  op_full,
	output logic  op_push,
	output op_t   op
);

	logic [USED_W-1:0]  used_q;
	logic [TRACK_W-1:0] total_q;
	logic [TRACK_W:0]   sum;
	logic               append_ok;
	logic               lookup_ok;

	assign full    = op_full;
	assign op_push = push && !op_full;

	// carry out of the sum means the total would reach the track limit
	assign sum       = {1'b0, total_q} + (TRACK_W+1)'(item.tracks_in_block);
	assign append_ok = (used_q != USED_W'(MAX_BLOCKS)) && !sum[TRACK_W];
	assign lookup_ok = item.track_number < total_q;

	always_comb begin
		op.cmd                = item.cmd;
		op.wr_index           = used_q[ADDR_W-1:0];
		op.entry.offset       = item.stream_offset;
		op.entry.length       = item.block_bytes;
		op.entry.first_track  = total_q;
		op.entry.track_count  = item.tracks_in_block;
		op.track_number       = item.track_number;
		if (item.cmd == CMD_APPEND) begin
			op.ok           = append_ok;
			op.total_tracks = append_ok ? sum[TRACK_W-1:0] : total_q;
		end else begin
			op.ok           = lookup_ok;
			op.total_tracks = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			total_q <= '0;
		end else if (op_push && item.cmd == CMD_APPEND && append_ok) begin
			used_q  <= used_q + USED_W'(1);
			total_q <= sum[TRACK_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_total_follows_append: assert property (@(posedge clk) disable iff (!arst_n)
		op_push && op.cmd == CMD_APPEND && op.ok |=> total_q == $past(op.total_tracks))
		else $error("track total not updated by accepted append");
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(MAX_BLOCKS))
		else $error("entry count beyond table size");
`endif

endmodule

FILE: src/trit_op_fifo.sv
// ----------------------------------------------------------------------------
// trit_op_fifo: short queue of classified operations between front and back
// ----------------------------------------------------------------------------
module trit_op_fifo import trit_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_data,
	output logic full,
	input  logic rd_en,
	output op_t  rd_data,
	output logic empty
);

	op_t                   slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("operation queue count overflow");
`endif

endmodule

FILE: src/trit_back.sv
// ----------------------------------------------------------------------------
// trit_back: carries out queued operations on the entry memory
// writes appended entries, scans entries in order for lookups, holds result
// ----------------------------------------------------------------------------
module trit_back import trit_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    op_empty,
	input  op_t     op_in,
	output logic    op_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	entry_t            mem [MAX_BLOCKS];
	entry_t            rd_data_s1;
	logic              rd_vld_s1;
	back_state_t       state_q;
	op_t               op_q;
	entry_t            found_q;
	logic [ADDR_W-1:0] idx_q;
	result_t           res_q;
	logic              res_valid_q;
	logic              mem_we;
	logic              hit;
	logic              slot_free;
	logic [TRACK_W:0]  range_end;

	assign op_pop    = (state_q == ST_IDLE) && !op_empty;
	assign mem_we    = op_pop && op_in.cmd == CMD_APPEND && op_in.ok;
	assign slot_free = !res_valid_q || pop;
	assign empty     = !res_valid_q;
	assign result    = res_q;

	assign range_end = {1'b0, rd_data_s1.first_track} + (TRACK_W+1)'(rd_data_s1.track_count);
	assign hit = rd_vld_s1 && (rd_data_s1.track_count != '0)
		&& (op_q.track_number >= rd_data_s1.first_track)
		&& ({1'b0, op_q.track_number} < range_end);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[op_in.wr_index] <= op_in.entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[idx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (op_pop) begin
					op_q    <= op_in;
					found_q <= '0;
				end
				idx_q <= '0;
			end
			ST_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (hit) begin
					found_q <= rd_data_s1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					res_q.ok                <= op_q.ok;
					res_q.found_offset      <= found_q.offset;
					res_q.found_length      <= found_q.length;
					res_q.found_first_track <= found_q.first_track;
					res_q.total_tracks      <= op_q.total_tracks;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && !hit;
			// a new result replaces the one taken in the same cycle
			if (state_q == ST_EMIT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_pop) begin
						state_q <= (op_in.cmd == CMD_LOOKUP && op_in.ok) ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_scan_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> op_q.cmd == CMD_LOOKUP && op_q.ok)
		else $error("scan running for an operation that needs none");
	a_emit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && slot_free |=> res_valid_q && state_q == ST_IDLE)
		else $error("result not loaded on emit");
`endif

endmodule

FILE: sim/track_range_index_table_checker.sv
// ----------------------------------------------------------------------------
// track_range_index_table_checker: scoreboard for the track range index table
// watches both queue ports, predicts every result from its own copy of the
// table and compares the results field by field in arrival order
// ----------------------------------------------------------------------------
module track_range_index_table_checker import trit_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      pending,
	output int      stored_blocks,
	output int      tracks_known,
	output int      appends_rejected,
	output int      lookup_hits,
	output int      lookup_misses
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the table
	logic [OFFSET_W-1:0] blk_offset [MAX_BLOCKS];
	logic [LEN_W-1:0]    blk_length [MAX_BLOCKS];
	logic [TRACK_W-1:0]  blk_first  [MAX_BLOCKS];
	logic [TCOUNT_W-1:0] blk_tracks [MAX_BLOCKS];
	logic [USED_W-1:0]   blk_used     = '0;
	logic [TRACK_W-1:0]  tracks_total = '0;

	result_t owed_results [$];
	int      err_cnt  = 0;
	int      rej_cnt  = 0;
	int      hit_cnt  = 0;
	int      miss_cnt = 0;

	// one table operation: updates the shadow table, returns its result
	function automatic result_t table_step(input item_t it);
		result_t          r;
		logic [TRACK_W:0] sum;
		logic             hit;
		r   = '0;
		hit = 1'b0;
		if (it.cmd == CMD_APPEND) begin
			sum = {1'b0, tracks_total} + (TRACK_W+1)'(it.tracks_in_block);
			if (blk_used < MAX_BLOCKS && !sum[TRACK_W]) begin
				blk_offset[blk_used] = it.stream_offset;
				blk_length[blk_used] = it.block_bytes;
				blk_first[blk_used]  = tracks_total;
				blk_tracks[blk_used] = it.tracks_in_block;
				blk_used             = blk_used + 1'b1;
				tracks_total         = sum[TRACK_W-1:0];
				r.ok                 = 1'b1;
			end else begin
				rej_cnt++;
			end
		end else begin
			if (it.track_number < tracks_total) begin
				// first block in append order that covers the track
				for (int i = 0; i < blk_used; i++) begin
					if (!hit && blk_tracks[i] != '0 && it.track_number >= blk_first[i] &&
						{1'b0, it.track_number} < {1'b0, blk_first[i]} + blk_tracks[i]) begin
						hit                 = 1'b1;
						r.ok                = 1'b1;
						r.found_offset      = blk_offset[i];
						r.found_length      = blk_length[i];
						r.found_first_track = blk_first[i];
					end
				end
			end
			if (hit)
				hit_cnt++;
			else
				miss_cnt++;
		end
		r.total_tracks = tracks_total;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		result_t want;
		if (!arst_n) begin
			blk_used     = '0;
			tracks_total = '0;
			owed_results.delete();
		end else begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					err_cnt++;
					$display("%0t: result with none expected, expected nothing, got %h",
						$time, result);
				end else begin
					want = owed_results.pop_front();
					compare_field("ok", 32'(want.ok), 32'(result.ok));
					compare_field("found_offset", 32'(want.found_offset),
						32'(result.found_offset));
					compare_field("found_length", 32'(want.found_length),
						32'(result.found_length));
					compare_field("found_first_track", 32'(want.found_first_track),
						32'(result.found_first_track));
					compare_field("total_tracks", 32'(want.total_tracks),
						32'(result.total_tracks));
				end
			end
			if (push && !full)
				owed_results.push_back(table_step(item));
		end
		errors           <= err_cnt;
		pending          <= owed_results.size();
		stored_blocks    <= blk_used;
		tracks_known     <= tracks_total;
		appends_rejected <= rej_cnt;
		lookup_hits      <= hit_cnt;
		lookup_misses    <= miss_cnt;
	end

endmodule

FILE: sim/tb_track_range_index_table_top.sv
// ----------------------------------------------------------------------------
// tb_track_range_index_table_top: testbench of the track range index table
// drives appends and lookups in random bursts against a stalling receiver;
// a scoreboard beside the block predicts and checks every result
// ----------------------------------------------------------------------------
module tb_track_range_index_table_top;
	import trit_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// no accept on either side for this long means the block is stuck;
	// a lookup walk reads at most MAX_BLOCKS entries, receiver holds are short
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 2000;

	typedef enum int {
		POP_DRAIN,
		POP_JITTER,
		POP_HOLD
	} pop_mode_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push;
	logic    full;
	item_t   req_item;
	logic    empty;
	logic    pop;
	result_t rsp_result;

	int errors, pending, stored_blocks, tracks_known;
	int appends_rejected, lookup_hits, lookup_misses;

	int burst_left   = 1;
	int items_sent   = 0;
	int idle_cycles  = 0;

	always #2 clk = ~clk;

	track_range_index_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (req_item),
		.empty  (empty),
		.pop    (pop),
		.result (rsp_result)
	);

	track_range_index_table_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.item             (req_item),
		.empty            (empty),
		.pop              (pop),
		.result           (rsp_result),
		.errors           (errors),
		.pending          (pending),
		.stored_blocks    (stored_blocks),
		.tracks_known     (tracks_known),
		.appends_rejected (appends_rejected),
		.lookup_hits      (lookup_hits),
		.lookup_misses    (lookup_misses)
	);

	// item with every field random, so unused fields toggle too
	function automatic item_t noise_item();
		item_t it;
		it.cmd             = 1'($urandom);
		it.stream_offset   = OFFSET_W'($urandom);
		it.block_bytes     = LEN_W'($urandom);
		it.tracks_in_block = TCOUNT_W'($urandom);
		it.track_number    = TRACK_W'($urandom);
		return it;
	endfunction

	function automatic item_t append_item(input logic [OFFSET_W-1:0] off,
		input logic [LEN_W-1:0] len, input logic [TCOUNT_W-1:0] cnt);
		item_t it;
		it                 = noise_item();
		it.cmd             = CMD_APPEND;
		it.stream_offset   = off;
		it.block_bytes     = len;
		it.tracks_in_block = cnt;
		return it;
	endfunction

	function automatic item_t lookup_item(input logic [TRACK_W-1:0] trk);
		item_t it;
		it              = noise_item();
		it.cmd          = CMD_LOOKUP;
		it.track_number = trk;
		return it;
	endfunction

	// hand one item over; bursts of random length, random gaps in between
	task automatic send(input item_t it);
		int gap;
		push     <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (full);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			// a quarter of the bursts run straight into the next one
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending until the block has handed back everything it owes
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver: alternates between taking every result, random pops and holds
	initial begin : receiver
		pop_mode_t mode;
		int        span;
		pop <= 1'b0;
		forever begin
			mode = pop_mode_t'($urandom_range(0, 2));
			span = $urandom_range(1, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					POP_DRAIN:  pop <= 1'b1;
					POP_JITTER: pop <= 1'($urandom);
					default:    pop <= 1'b0;
				endcase
			end
		end
	end

	// watchdog on cycles in which no item moves on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, nothing moved for %0d cycles", $time, idle_cycles);
			$display("tb_track_range_index_table_top NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int    pick;
		item_t it;
		push     <= 1'b0;
		req_item <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lookups on the empty table miss, at both ends of the range
		send(lookup_item('0));
		send(lookup_item('1));
		// widest block, then a zero-track block that covers nothing
		send(append_item('1, '1, 8'd255));
		send(append_item('0, '0, 8'd0));
		send(append_item(31'h5555_5555, 16'haaaa, 8'd1));
		send(append_item(31'h2aaa_aaaa, 16'h5555, 8'd128));
		// first and last track of the first block
		send(lookup_item(16'd0));
		send(lookup_item(16'd254));
		// track right after the zero-track block must skip it
		send(lookup_item(16'd255));
		send(lookup_item(16'd256));
		send(lookup_item(16'd383));
		// exactly at the total and far above it: misses
		send(lookup_item(16'd384));
		send(lookup_item(16'hffff));
		send(append_item(31'h0000_0001, 16'h0001, 8'd0));
		send(append_item(31'h4000_0000, 16'h8000, 8'd255));
		send(lookup_item(16'd384));
		send(lookup_item(16'd638));
		send(lookup_item(16'd639));
		drain();

		// random part: appends mixed into lookups, so the table fills up
		// part way through and later appends are turned away as table full;
		// the track total cannot reach the limit with this table size
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 500 == 250)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				case ($urandom_range(0, 9))
					0:       it = append_item(OFFSET_W'($urandom), LEN_W'($urandom), 8'd0);
					1:       it = append_item(OFFSET_W'($urandom), LEN_W'($urandom), 8'd255);
					default: it = append_item(OFFSET_W'($urandom), LEN_W'($urandom),
						TCOUNT_W'($urandom));
				endcase
			end else if (pick < 84 && tracks_known > 0) begin
				// mostly tracks that exist, to exercise the walk
				it = lookup_item(TRACK_W'($urandom_range(0, tracks_known - 1)));
			end else begin
				it = lookup_item(TRACK_W'($urandom));
			end
			send(it);
		end
		drain();

		// a late result would show up here as one nobody expects
		repeat (MAX_BLOCKS + 16) @(posedge clk);

		$display("sent %0d items: %0d blocks stored, %0d appends turned away",
			items_sent, stored_blocks, appends_rejected);
		$display("lookups: %0d hits, %0d misses, final track total %0d",
			lookup_hits, lookup_misses, tracks_known);
		if (errors == 0 && pending == 0) begin
			$display("tb_track_range_index_table_top OK");
		end else begin
			$display("tb_track_range_index_table_top NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/trit_pkg.sv
src/trit_front.sv
src/trit_op_fifo.sv
src/trit_back.sv
src/track_range_index_table_top.sv
sim/track_range_index_table_checker.sv
sim/tb_track_range_index_table_top.sv
